FILE: rtl/core/icmp_packet_checker_top_assert.svh
// Assertion macros for the ICMP packet checker top level.
`ifndef ICMP_PACKET_CHECKER_TOP_ASSERT_SVH
`define ICMP_PACKET_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk_i while out of reset.
`define ICMP_PC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk_i while out of reset.
`define ICMP_PC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/icmp_pc_pkg.sv
// Shared types, constants and functions of the ICMP packet checker.
`timescale 1ns / 1ps
`default_nettype none

package icmp_pc_pkg;

  // Width of the saturating byte counter
  localparam int LENGTH_BITS = 16;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // Byte positions inside the ICMP part
  localparam logic [LENGTH_BITS-1:0] REL_TYPE   = LENGTH_BITS'(0);
  localparam logic [LENGTH_BITS-1:0] REL_CODE   = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] REL_CSUM_H = LENGTH_BITS'(2);
  localparam logic [LENGTH_BITS-1:0] REL_CSUM_L = LENGTH_BITS'(3);
  localparam logic [LENGTH_BITS-1:0] REL_IN_IHL = LENGTH_BITS'(8);
  localparam logic [LENGTH_BITS-1:0] REL_IN_PRO = LENGTH_BITS'(17);

  // Length limits
  localparam int ICMP_HDR_BYTES = 8;
  localparam int INNER_IP_MIN   = 20;
  localparam int UDP_HDR_BYTES  = 8;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // Result codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_MISMATCH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    IN_UDP_OK    = 2'd0,
    IN_IP_SHORT  = 2'd1,
    IN_NOT_UDP   = 2'd2,
    IN_UDP_SHORT = 2'd3
  } inner_e;

  // Packet state as it stands after the current byte
  typedef struct packed {
    logic [LENGTH_BITS-1:0] byte_count;
    logic [5:0]             hdr_len;
    logic [15:0]            sum_final;
    logic [15:0]            checksum;
    logic [15:0]            type_code;
    logic [7:0]             inner_proto;
    logic [5:0]             inner_hl;
  } step_t;

  // One result item
  typedef struct packed {
    logic [15:0] udp_offset;
    logic [15:0] inner_ip_offset;
    inner_e      inner_status;
    logic [7:0]  icmp_code;
    logic [7:0]  icmp_type;
    logic [5:0]  ip_header_bytes;
    status_e     status;
  } result_t;

  // Ones-complement add with end-around carry
  function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, word};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/icmp_pc_accum.sv
// Per-byte packet state: header length, checksum fold and field capture.
`timescale 1ns / 1ps
`default_nettype none

module icmp_pc_accum (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          last_byte_i,
  output icmp_pc_pkg::step_t                 step_o
);

  localparam int LB = icmp_pc_pkg::LENGTH_BITS;

  logic [LB-1:0] byte_count_q, byte_count_d;
  logic [5:0]    hdr_len_q, hdr_len_d;
  logic [15:0]   sum_q, sum_d;
  logic [7:0]    held_q, held_d;
  logic          odd_q, odd_d;
  logic [15:0]   csum_q, csum_d;
  logic [15:0]   tc_q, tc_d;
  logic [7:0]    proto_q, proto_d;
  logic [5:0]    inner_hl_q, inner_hl_d;

  logic [5:0]    hl;
  logic          in_icmp;
  logic [LB-1:0] rel;
  logic [7:0]    v;
  logic [15:0]   word;
  logic [15:0]   folded;

  // Header length and position inside the ICMP part
  always_comb begin
    hl      = (byte_count_q == '0) ? {data_byte_i[3:0], 2'b00} : hdr_len_q;
    in_icmp = byte_count_q >= {{(LB-6){1'b0}}, hl};
    rel     = byte_count_q - {{(LB-6){1'b0}}, hl};
    v       = (rel == icmp_pc_pkg::REL_CSUM_H || rel == icmp_pc_pkg::REL_CSUM_L) ?
              8'h00 : data_byte_i;
  end

  // One fold covers both the completed word and the final odd-byte pad
  always_comb begin
    if (in_icmp) begin
      word = odd_q ? {held_q, v} : {v, 8'h00};
    end else begin
      word = odd_q ? {held_q, 8'h00} : 16'h0000;
    end
    folded = icmp_pc_pkg::fold_add(sum_q, word);
  end

  // Next state for this byte
  always_comb begin
    hdr_len_d    = hl;
    sum_d        = sum_q;
    held_d       = held_q;
    odd_d        = odd_q;
    csum_d       = csum_q;
    tc_d         = tc_q;
    proto_d      = proto_q;
    inner_hl_d   = inner_hl_q;
    byte_count_d = (byte_count_q < icmp_pc_pkg::LEN_MAX) ? byte_count_q + LB'(1) :
                   icmp_pc_pkg::LEN_MAX;
    if (in_icmp) begin
      if (rel == icmp_pc_pkg::REL_TYPE)   tc_d[15:8]   = data_byte_i;
      if (rel == icmp_pc_pkg::REL_CODE)   tc_d[7:0]    = data_byte_i;
      if (rel == icmp_pc_pkg::REL_CSUM_H) csum_d[15:8] = data_byte_i;
      if (rel == icmp_pc_pkg::REL_CSUM_L) csum_d[7:0]  = data_byte_i;
      if (rel == icmp_pc_pkg::REL_IN_IHL) inner_hl_d   = {data_byte_i[3:0], 2'b00};
      if (rel == icmp_pc_pkg::REL_IN_PRO) proto_d      = data_byte_i;
      if (!odd_q) begin
        held_d = v;
        odd_d  = 1'b1;
      end else begin
        sum_d = folded;
        odd_d = 1'b0;
      end
    end
  end

  // Post-byte view for the result stage
  always_comb begin
    step_o.byte_count  = byte_count_d;
    step_o.hdr_len     = hdr_len_d;
    step_o.sum_final   = folded;
    step_o.checksum    = csum_d;
    step_o.type_code   = tc_d;
    step_o.inner_proto = proto_d;
    step_o.inner_hl    = inner_hl_d;
  end

  // State registers, cleared after each last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      hdr_len_q    <= '0;
      sum_q        <= '0;
      held_q       <= '0;
      odd_q        <= 1'b0;
      csum_q       <= '0;
      tc_q         <= '0;
      proto_q      <= '0;
      inner_hl_q   <= '0;
    end else if (accept_i && last_byte_i) begin
      byte_count_q <= '0;
      hdr_len_q    <= '0;
      sum_q        <= '0;
      held_q       <= '0;
      odd_q        <= 1'b0;
      csum_q       <= '0;
      tc_q         <= '0;
      proto_q      <= '0;
      inner_hl_q   <= '0;
    end else if (accept_i) begin
      byte_count_q <= byte_count_d;
      hdr_len_q    <= hdr_len_d;
      sum_q        <= sum_d;
      held_q       <= held_d;
      odd_q        <= odd_d;
      csum_q       <= csum_d;
      tc_q         <= tc_d;
      proto_q      <= proto_d;
      inner_hl_q   <= inner_hl_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/icmp_pc_result.sv
// Final verdict logic and the output register.
`timescale 1ns / 1ps
`default_nettype none

module icmp_pc_result (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire logic                 out_ready_i,
  input  wire icmp_pc_pkg::step_t   step_i,
  output logic                      out_valid_o,
  output icmp_pc_pkg::result_t      result_o
);

  localparam int LB = icmp_pc_pkg::LENGTH_BITS;

  logic                 out_valid_q, out_valid_d;
  icmp_pc_pkg::result_t res_q, res_d;

  logic [LB-1:0] hl_ext;
  logic          short_hdr;
  logic [LB:0]   icmplen;
  logic [LB:0]   udp_need;
  logic [15:0]   inner_off;

  // Length checks
  always_comb begin
    hl_ext    = {{(LB-6){1'b0}}, step_i.hdr_len};
    short_hdr = step_i.byte_count < hl_ext;
    icmplen   = short_hdr ? '0 : {1'b0, step_i.byte_count - hl_ext};
    udp_need  = (LB+1)'(icmp_pc_pkg::ICMP_HDR_BYTES + icmp_pc_pkg::UDP_HDR_BYTES) +
                {{(LB-5){1'b0}}, step_i.inner_hl};
    inner_off = {10'd0, step_i.hdr_len} + 16'(icmp_pc_pkg::ICMP_HDR_BYTES);
  end

  // Result item
  always_comb begin
    if (short_hdr || icmplen < (LB+1)'(icmp_pc_pkg::ICMP_HDR_BYTES)) begin
      res_d.status = icmp_pc_pkg::ST_SHORT;
    end else if (~step_i.sum_final != step_i.checksum) begin
      res_d.status = icmp_pc_pkg::ST_MISMATCH;
    end else begin
      res_d.status = icmp_pc_pkg::ST_OK;
    end

    if (short_hdr ||
        icmplen < (LB+1)'(icmp_pc_pkg::ICMP_HDR_BYTES + icmp_pc_pkg::INNER_IP_MIN)) begin
      res_d.inner_status = icmp_pc_pkg::IN_IP_SHORT;
    end else if (step_i.inner_proto != icmp_pc_pkg::PROTO_UDP) begin
      res_d.inner_status = icmp_pc_pkg::IN_NOT_UDP;
    end else if (icmplen < udp_need) begin
      res_d.inner_status = icmp_pc_pkg::IN_UDP_SHORT;
    end else begin
      res_d.inner_status = icmp_pc_pkg::IN_UDP_OK;
    end

    res_d.ip_header_bytes = step_i.hdr_len;
    res_d.icmp_type       = step_i.type_code[15:8];
    res_d.icmp_code       = step_i.type_code[7:0];
    res_d.inner_ip_offset = inner_off;
    res_d.udp_offset      = (res_d.inner_status == icmp_pc_pkg::IN_UDP_OK ||
                             res_d.inner_status == icmp_pc_pkg::IN_UDP_SHORT) ?
                            inner_off + {10'd0, step_i.inner_hl} : 16'd0;
  end

  // Output valid flag
  always_comb begin
    if (load_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/icmp_packet_checker_top.sv
// Top level of the ICMP packet checker: stream ports and handshake.
`timescale 1ns / 1ps
`default_nettype none

// Checks a received IPv4 packet carrying ICMP, fed one byte per cycle from the
// start of the outer IP header, with tlast on the final byte. The per-byte
// checksum fold and field capture settle in the same cycle the byte is
// accepted. The result request appears on the master side the cycle after
// the last byte and sits in a single output register; the input side stays
// ready while that register is empty or being taken, so full rate holds as
// long as results are drained. The checksum field counts as zero and an odd
// trailing byte is padded with zero. A packet shorter than its IP header is
// reported as too short.
module icmp_packet_checker_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,   // last_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [1:0] status, [7:2] ip_header_bytes, [15:8] icmp_type, [23:16] icmp_code,
  // [25:24] inner_status, [41:26] inner_ip_offset, [57:42] udp_offset, rest 0
  output logic [63:0]      m_axis_tdata_o
);

  logic                 accept;
  icmp_pc_pkg::step_t   step;
  icmp_pc_pkg::result_t res;

  // Input handshake
  assign s_axis_tready_o = !m_axis_tvalid_o || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  icmp_pc_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata_i),
    .last_byte_i (s_axis_tlast_i),
    .step_o      (step)
  );

  icmp_pc_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .step_i      (step),
    .out_valid_o (m_axis_tvalid_o),
    .result_o    (res)
  );

  // Pack the result request
  assign m_axis_tdata_o = {6'd0, 58'(res)};

  // Checks
  `include "icmp_packet_checker_top_assert.svh"

  `ICMP_PC_ASSERT_NOW(a_stall_blocks_input, m_axis_tvalid_o && !m_axis_tready_i, !s_axis_tready_o, "input accepted while result stalled")
  `ICMP_PC_ASSERT_NEXT(a_last_gives_result, accept && s_axis_tlast_i, m_axis_tvalid_o, "no result after last byte")
  `ICMP_PC_ASSERT_NOW(a_status_range, m_axis_tvalid_o, m_axis_tdata_o[1:0] != 2'd3, "status code out of range")
  `ICMP_PC_ASSERT_NOW(a_inner_offset, m_axis_tvalid_o, m_axis_tdata_o[41:26] == {10'd0, m_axis_tdata_o[7:2]} + 16'd8, "inner offset mismatch")

endmodule

`default_nettype wire
